// ===== rtl/core/tlsg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsg_pkg
// Shared codes and types for the turtle line segment generator: command
// symbols, result status codes, register indexes and the stack frame layout.
// ----------------------------------------------------------------------------
package tlsg_pkg;

   localparam int unsigned CoordW = 20;
   localparam int unsigned DirW   = 16;
   localparam int unsigned LenW   = 16;
   localparam int unsigned SymW   = 8;
   localparam int unsigned StatW  = 2;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 20;

   // command symbols (ASCII)
   localparam logic [SymW-1:0] SYM_X      = 8'h58;
   localparam logic [SymW-1:0] SYM_Y      = 8'h59;
   localparam logic [SymW-1:0] SYM_PLUS   = 8'h2B;
   localparam logic [SymW-1:0] SYM_MINUS  = 8'h2D;
   localparam logic [SymW-1:0] SYM_PUSH   = 8'h5B;
   localparam logic [SymW-1:0] SYM_POP    = 8'h5D;

   // result status
   localparam logic [StatW-1:0] ST_SEGMENT   = 2'd0;
   localparam logic [StatW-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [StatW-1:0] ST_UNDERFLOW = 2'd2;

   // register indexes
   localparam logic [CsrIdxW-1:0] REG_START_X  = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_START_Y  = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_STEP_LEN = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_COS      = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_SIN      = 3'd4;

   // unit vector along +x in Q2.14
   localparam logic signed [DirW-1:0] DIR_UNIT = 16'sd16384;

   typedef struct packed {
      logic signed [CoordW-1:0] pos_x;
      logic signed [CoordW-1:0] pos_y;
      logic signed [DirW-1:0]   dir_x;
      logic signed [DirW-1:0]   dir_y;
   } frame_type;

endpackage

// ===== rtl/core/turtle_line_segment_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turtle_line_segment_generator_top
// Turtle command interpreter with a save/restore stack held in a RAM.
// ----------------------------------------------------------------------------
// Takes one sentence symbol per cycle and produces at most one result beat per
// symbol, in the cycle after the symbol is taken. Position and heading are
// updated as each symbol is taken; the saved frames live in a one-port-write,
// one-port-read synchronous RAM of STACK_DEPTH entries, and the entry on top of
// the stack is kept pre-read in a register (with forwarding from a push in the
// same cycle) so that back-to-back pushes and pops run at full rate. The input
// stalls only when the symbol would produce a result and the output register
// holds a beat that is not being taken. The RAM needs no clearing after reset.
module turtle_line_segment_generator_top
   import tlsg_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   // symbol input
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [SymW-1:0]          req_symbol,
   input  logic                     req_first,
   // segment output
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [CoordW-1:0] rsp_x_from,
   output logic signed [CoordW-1:0] rsp_y_from,
   output logic signed [CoordW-1:0] rsp_x_to,
   output logic signed [CoordW-1:0] rsp_y_to,
   output logic [StatW-1:0]         rsp_status,
   // register writes
   input  logic                     csr_wr_en,
   input  logic [CsrIdxW-1:0]       csr_index,
   input  logic [CsrDataW-1:0]      csr_wr_data
);

   localparam int unsigned LvlW  = $clog2(STACK_DEPTH + 1);
   localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [LvlW-1:0] LvlFull = LvlW'(STACK_DEPTH);
   localparam logic [LvlW-1:0] LvlOne  = LvlW'(1);

   // configuration
   logic signed [CoordW-1:0] start_x_ff, start_y_ff;
   logic [LenW-1:0]          step_len_ff;
   logic signed [DirW-1:0]   cos_ff, sin_ff;

   // turtle state
   logic signed [CoordW-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [DirW-1:0]   dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic [LvlW-1:0]          level_ff, level_in;

   // stack RAM and pre-read top entry
   frame_type                stack_mem [STACK_DEPTH];
   frame_type                top_ff;
   frame_type                push_frame;
   logic                     mem_we;
   logic [AddrW-1:0]         wr_addr, rd_addr;
   logic [LvlW-1:0]          level_m1;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [CoordW-1:0] x_from_ff, y_from_ff, x_to_ff, y_to_ff;
   logic [StatW-1:0]         status_ff;

   // per-symbol working values
   logic                     accept, emit, is_move, is_push, is_pop, is_rot_p, is_rot_m;
   logic                     full, empty;
   logic signed [CoordW-1:0] base_px, base_py, to_x, to_y;
   logic signed [DirW-1:0]   base_dx, base_dy, rot_x, rot_y;
   logic [LvlW-1:0]          base_lvl;
   logic signed [LenW:0]     len_s;
   logic signed [32:0]       step_px, step_py, rnd_px, rnd_py;
   logic signed [31:0]       mul_xc, mul_ys, mul_xs, mul_yc;
   logic signed [32:0]       sum_x, sum_y, rnd_x, rnd_y;
   logic [StatW-1:0]         status_in;

   function automatic logic signed [DirW-1:0] sat_dir(input logic signed [32:0] v);
      logic signed [18:0] t;
      t = v[18:0];
      if (t > 19'sd32767)       return 16'sh7FFF;
      else if (t < -19'sd32768) return 16'sh8000;
      else                      return t[DirW-1:0];
   endfunction

   // ---- configuration writes ----
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff  <= 20'sd6400;
         start_y_ff  <= 20'sd4800;
         step_len_ff <= 16'd8000;
         cos_ff      <= 16'sd0;
         sin_ff      <= 16'sd16384;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_START_X:  start_x_ff  <= csr_wr_data;
            REG_START_Y:  start_y_ff  <= csr_wr_data;
            REG_STEP_LEN: step_len_ff <= csr_wr_data[LenW-1:0];
            REG_COS:      cos_ff      <= csr_wr_data[DirW-1:0];
            REG_SIN:      sin_ff      <= csr_wr_data[DirW-1:0];
            default: ;
         endcase
      end
   end

   // ---- state as seen by this symbol (home first if requested) ----
   always_comb begin
      if (req_first) begin
         base_px  = start_x_ff;
         base_py  = start_y_ff;
         base_dx  = DIR_UNIT;
         base_dy  = '0;
         base_lvl = '0;
      end else begin
         base_px  = pos_x_ff;
         base_py  = pos_y_ff;
         base_dx  = dir_x_ff;
         base_dy  = dir_y_ff;
         base_lvl = level_ff;
      end
   end

   assign is_move  = (req_symbol == SYM_X) || (req_symbol == SYM_Y);
   assign is_rot_p = (req_symbol == SYM_PLUS);
   assign is_rot_m = (req_symbol == SYM_MINUS);
   assign is_push  = (req_symbol == SYM_PUSH);
   assign is_pop   = (req_symbol == SYM_POP);
   assign full     = (base_lvl == LvlFull);
   assign empty    = (base_lvl == '0);
   assign emit     = is_move || (is_push && full) || (is_pop && empty);

   assign req_stall = emit && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // step: to = pos + round(dir * len / 2^14), wraps at 20 bits
   assign len_s   = signed'({1'b0, step_len_ff});
   assign step_px = 33'(base_dx) * 33'(len_s);
   assign step_py = 33'(base_dy) * 33'(len_s);
   assign rnd_px  = (step_px + 33'sd8192) >>> 14;
   assign rnd_py  = (step_py + 33'sd8192) >>> 14;
   assign to_x    = base_px + rnd_px[CoordW-1:0];
   assign to_y    = base_py + rnd_py[CoordW-1:0];

   // rotation by +/- angle
   assign mul_xc = 32'(base_dx) * 32'(cos_ff);
   assign mul_ys = 32'(base_dy) * 32'(sin_ff);
   assign mul_xs = 32'(base_dx) * 32'(sin_ff);
   assign mul_yc = 32'(base_dy) * 32'(cos_ff);

   always_comb begin
      if (is_rot_p) begin
         sum_x = 33'(mul_xc) - 33'(mul_ys);
         sum_y = 33'(mul_xs) + 33'(mul_yc);
      end else begin
         sum_x = 33'(mul_xc) + 33'(mul_ys);
         sum_y = 33'(mul_yc) - 33'(mul_xs);
      end
   end
   assign rnd_x = (sum_x + 33'sd8192) >>> 14;
   assign rnd_y = (sum_y + 33'sd8192) >>> 14;
   assign rot_x = sat_dir(rnd_x);
   assign rot_y = sat_dir(rnd_y);

   // ---- next state ----
   always_comb begin
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      dir_x_in  = dir_x_ff;
      dir_y_in  = dir_y_ff;
      level_in  = level_ff;
      mem_we    = 1'b0;
      status_in = ST_SEGMENT;
      if (accept) begin
         pos_x_in = base_px;
         pos_y_in = base_py;
         dir_x_in = base_dx;
         dir_y_in = base_dy;
         level_in = base_lvl;
         if (is_move) begin
            pos_x_in = to_x;
            pos_y_in = to_y;
         end else if (is_rot_p || is_rot_m) begin
            dir_x_in = rot_x;
            dir_y_in = rot_y;
         end else if (is_push) begin
            if (full) begin
               status_in = ST_OVERFLOW;
            end else begin
               mem_we   = 1'b1;
               level_in = base_lvl + LvlOne;
            end
         end else if (is_pop) begin
            if (empty) begin
               status_in = ST_UNDERFLOW;
            end else begin
               level_in = base_lvl - LvlOne;
               pos_x_in = top_ff.pos_x;
               pos_y_in = top_ff.pos_y;
               dir_x_in = top_ff.dir_x;
               dir_y_in = top_ff.dir_y;
            end
         end
      end
   end

   // ---- stack RAM: write at level, keep entry level-1 of the next level read ----
   assign push_frame = '{pos_x: base_px, pos_y: base_py, dir_x: base_dx, dir_y: base_dy};
   assign wr_addr    = base_lvl[AddrW-1:0];
   assign level_m1   = level_in - LvlOne;
   assign rd_addr    = level_m1[AddrW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_addr] <= push_frame;
      end
      // a push makes the written entry the new top
      if (mem_we && (wr_addr == rd_addr)) begin
         top_ff <= push_frame;
      end else begin
         top_ff <= stack_mem[rd_addr];
      end
   end

   // ---- turtle registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= 20'sd6400;
         pos_y_ff <= 20'sd4800;
         dir_x_ff <= DIR_UNIT;
         dir_y_ff <= '0;
         level_ff <= '0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         dir_x_ff <= dir_x_in;
         dir_y_ff <= dir_y_in;
         level_ff <= level_in;
      end
   end

   // ---- output register ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         x_from_ff <= base_px;
         y_from_ff <= base_py;
         x_to_ff   <= is_move ? to_x : base_px;
         y_to_ff   <= is_move ? to_y : base_py;
         status_ff <= status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_x_from = x_from_ff;
   assign rsp_y_from = y_from_ff;
   assign rsp_x_to   = x_to_ff;
   assign rsp_y_to   = y_to_ff;
   assign rsp_status = status_ff;

endmodule

// ===== rtl/core/tlsg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsg_checker
// Port-level checks for the turtle line segment generator, bound to the top.
// ----------------------------------------------------------------------------
module tlsg_checker
   import tlsg_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic [SymW-1:0]          req_symbol,
   input logic                     req_first,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [CoordW-1:0] rsp_x_from,
   input logic signed [CoordW-1:0] rsp_y_from,
   input logic signed [CoordW-1:0] rsp_x_to,
   input logic signed [CoordW-1:0] rsp_y_to,
   input logic [StatW-1:0]         rsp_status
);

   logic req_beat;
   assign req_beat = req_valid && !req_stall;

   // a stalled result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // stack errors report the current position as a zero-length segment
   a_err_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_SEGMENT) |->
         (rsp_x_from == rsp_x_to) && (rsp_y_from == rsp_y_to))
      else $error("stack error beat with nonzero length");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_SEGMENT) || (rsp_status == ST_OVERFLOW) ||
                    (rsp_status == ST_UNDERFLOW))
      else $error("bad status code");

   // a pop right after homing always underflows
   a_home_pop: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_first && (req_symbol == SYM_POP) |=>
         rsp_valid && (rsp_status == ST_UNDERFLOW))
      else $error("pop on empty stack not flagged");

   // a turn produces no beat
   a_turn_quiet: assert property (@(posedge clock) disable iff (reset)
      req_beat && !rsp_valid && ((req_symbol == SYM_PLUS) || (req_symbol == SYM_MINUS))
         |=> !rsp_valid)
      else $error("turn produced a result beat");

endmodule

bind turtle_line_segment_generator_top tlsg_checker u_tlsg_checker (.*);

// ===== tb/turtle_line_segment_generator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turtle_line_segment_generator_top_tb
// Drives turtle command sentences into the segment generator and checks every
// result beat against a cycle-free model of the turtle: position, heading,
// save/restore stack, overflow and underflow. Runs several register settings,
// random idle gaps on both channels and long output holds.
// ----------------------------------------------------------------------------
module turtle_line_segment_generator_top_tb;
   import tlsg_pkg::*;

   localparam int unsigned STACK_DEPTH   = 32;
   localparam int unsigned MAX_GAP       = 14;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned DRAIN_LIMIT   = 2000;
   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int unsigned PHASE_QUOTA   = 170;
   localparam int unsigned PHASE_COUNT   = 7;

   typedef struct packed {
      logic signed [CoordW-1:0] x_from;
      logic signed [CoordW-1:0] y_from;
      logic signed [CoordW-1:0] x_to;
      logic signed [CoordW-1:0] y_to;
      logic [StatW-1:0]         status;
   } segment_type;

   class segment_scoreboard;
      logic signed [CoordW-1:0] start_x, start_y;
      logic [LenW-1:0]          step_len;
      logic signed [DirW-1:0]   cos_a, sin_a;
      logic signed [CoordW-1:0] pos_x, pos_y;
      logic signed [DirW-1:0]   dir_x, dir_y;
      frame_type                saved [STACK_DEPTH];
      int unsigned              level;
      segment_type              pending [$];
      int unsigned              errors, beats, overflows, underflows;

      function new();
         start_x    = 20'sd6400;
         start_y    = 20'sd4800;
         step_len   = 16'd8000;
         cos_a      = 16'sd0;
         sin_a      = 16'sd16384;
         errors     = 0;
         beats      = 0;
         overflows  = 0;
         underflows = 0;
         go_home();
      endfunction

      function void go_home();
         pos_x = start_x;
         pos_y = start_y;
         dir_x = DIR_UNIT;
         dir_y = 16'sd0;
         level = 0;
      endfunction

      function void set_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
         case (idx)
            REG_START_X:  start_x  = data;
            REG_START_Y:  start_y  = data;
            REG_STEP_LEN: step_len = data[LenW-1:0];
            REG_COS:      cos_a    = data[DirW-1:0];
            REG_SIN:      sin_a    = data[DirW-1:0];
            default: ;
         endcase
      endfunction

      // Q2.14 product back to integer: nearest, ties toward +inf
      function longint round_q14(input longint p);
         return (p + 64'sd8192) >>> 14;
      endfunction

      function logic signed [DirW-1:0] clamp_dir(input longint v);
         if (v > 32767) return 16'sh7FFF;
         if (v < -32768) return 16'sh8000;
         return v[DirW-1:0];
      endfunction

      function void note_symbol(input logic [SymW-1:0] sym, input logic first);
         longint      c, s, len, dx, dy, nx, ny;
         segment_type seg;
         if (first) go_home();
         c   = cos_a;
         s   = sin_a;
         len = step_len;
         dx  = dir_x;
         dy  = dir_y;
         seg.x_from = pos_x;
         seg.y_from = pos_y;
         seg.x_to   = pos_x;
         seg.y_to   = pos_y;
         seg.status = ST_SEGMENT;
         case (sym)
            SYM_X, SYM_Y: begin
               nx = pos_x + round_q14(dx * len);
               ny = pos_y + round_q14(dy * len);
               seg.x_to = nx[CoordW-1:0];
               seg.y_to = ny[CoordW-1:0];
               pos_x = seg.x_to;
               pos_y = seg.y_to;
               pending.insert(pending.size(), seg);
            end
            SYM_PLUS: begin
               dir_x = clamp_dir(round_q14(dx * c - dy * s));
               dir_y = clamp_dir(round_q14(dx * s + dy * c));
            end
            SYM_MINUS: begin
               dir_x = clamp_dir(round_q14(dx * c + dy * s));
               dir_y = clamp_dir(round_q14(dy * c - dx * s));
            end
            SYM_PUSH: begin
               if (level >= STACK_DEPTH) begin
                  seg.status = ST_OVERFLOW;
                  pending.insert(pending.size(), seg);
               end else begin
                  saved[level] = '{pos_x, pos_y, dir_x, dir_y};
                  level++;
               end
            end
            SYM_POP: begin
               if (level == 0) begin
                  seg.status = ST_UNDERFLOW;
                  pending.insert(pending.size(), seg);
               end else begin
                  level--;
                  pos_x = saved[level].pos_x;
                  pos_y = saved[level].pos_y;
                  dir_x = saved[level].dir_x;
                  dir_y = saved[level].dir_y;
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(input string name, input logic signed [31:0] want,
                                  input logic signed [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_beat(input segment_type got);
         segment_type want;
         beats++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got %0d,%0d -> %0d,%0d st %0d",
                     $time, got.x_from, got.y_from, got.x_to, got.y_to, got.status);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (want.status == ST_OVERFLOW) overflows++;
         if (want.status == ST_UNDERFLOW) underflows++;
         compare_field("x_from", want.x_from, got.x_from);
         compare_field("y_from", want.y_from, got.y_from);
         compare_field("x_to", want.x_to, got.x_to);
         compare_field("y_to", want.y_to, got.y_to);
         compare_field("status", want.status, got.status);
      endfunction
   endclass

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   logic [SymW-1:0]          req_symbol  = '0;
   logic                     req_first   = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   logic signed [CoordW-1:0] rsp_x_from, rsp_y_from, rsp_x_to, rsp_y_to;
   logic [StatW-1:0]         rsp_status;
   logic                     csr_wr_en   = 1'b0;
   logic [CsrIdxW-1:0]       csr_index   = '0;
   logic [CsrDataW-1:0]      csr_wr_data = '0;

   segment_scoreboard recorder;
   bit                steady_send;
   int unsigned       counted_items;
   int unsigned       cycle_count = 0;

   turtle_line_segment_generator_top #(
      .STACK_DEPTH (STACK_DEPTH)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_symbol  (req_symbol),
      .req_first   (req_first),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_x_from  (rsp_x_from),
      .rsp_y_from  (rsp_y_from),
      .rsp_x_to    (rsp_x_to),
      .rsp_y_to    (rsp_y_to),
      .rsp_status  (rsp_status),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("turtle_line_segment_generator_top_tb failed");
         $finish;
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_symbol(input logic [SymW-1:0] sym, input logic first);
      int unsigned gap;
      gap = steady_send ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_symbol <= sym;
      req_first  <= first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      recorder.note_symbol(sym, first);
      counted_items++;
      @(negedge clock);
   endtask

   function automatic logic [SymW-1:0] any_command();
      case ($urandom_range(0, 5))
         0: return SYM_X;
         1: return SYM_Y;
         2: return SYM_PLUS;
         3: return SYM_MINUS;
         4: return SYM_PUSH;
         default: return SYM_POP;
      endcase
   endfunction

   // one sentence: a restart, optionally a deep push run, then a random body
   task automatic play_sentence(input bit deep);
      int unsigned body, pick;
      steady_send = ($urandom_range(0, 3) == 0);
      send_symbol(any_command(), 1'b1);
      if (deep) begin
         repeat ($urandom_range(33, 38)) begin
            if ($urandom_range(0, 3) == 0) send_symbol(SYM_X, 1'b0);
            send_symbol(SYM_PUSH, 1'b0);
         end
      end
      body = $urandom_range(4, 48);
      repeat (body) begin
         pick = $urandom_range(0, 99);
         if (pick < 30)
            send_symbol($urandom_range(0, 1) ? SYM_Y : SYM_X, 1'b0);
         else if (pick < 48)
            send_symbol($urandom_range(0, 1) ? SYM_MINUS : SYM_PLUS, 1'b0);
         else if (pick < 64)
            send_symbol(SYM_PUSH, 1'b0);
         else if (pick < 82) begin
            // mostly keep pops balanced, let an underflow through now and then
            if (recorder.level == 0 && $urandom_range(0, 3) != 0)
               send_symbol(SYM_X, 1'b0);
            else
               send_symbol(SYM_POP, 1'b0);
         end
         else if (pick < 94)
            send_symbol(8'($urandom_range(0, 255)), 1'b0);
         else
            send_symbol($urandom_range(0, 1) ? any_command() : 8'($urandom_range(0, 255)),
                        1'b1);
      end
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      recorder.set_reg(idx, data);
   endtask

   task automatic apply_settings(input int unsigned phase);
      logic [CsrDataW-1:0] sx, sy;
      logic [LenW-1:0]     len;
      logic [DirW-1:0]     c, s;
      sx  = CsrDataW'($urandom);
      sy  = CsrDataW'($urandom);
      len = LenW'($urandom);
      c   = DirW'($urandom);
      s   = DirW'($urandom);
      case (phase)
         1: begin   // 45 deg, largest step from the top corner: coordinates wrap
            sx = 20'h7FFFF; sy = 20'h7FFFF; len = 16'hFFFF; c = 16'd11585; s = 16'd11585;
         end
         2: begin   // zero step, no turn
            sx = 20'h80000; sy = 20'h80000; len = 16'h0000; c = 16'd16384; s = 16'd0;
         end
         3: begin   // half turn, short steps
            len = LenW'($urandom_range(1, 64)); c = -16'sd16384; s = 16'd0;
         end
         4: ;       // everything random, turns mostly saturate
         5: begin   // -30 deg, unit step
            sx = '0; sy = '0; len = 16'd1; c = 16'd14189; s = -16'sd8192;
         end
         default: begin
            c = 16'h8000; s = 16'h7FFF;
         end
      endcase
      // upper bits of the narrow registers are junk on purpose
      write_reg(REG_START_X, sx);
      write_reg(REG_START_Y, sy);
      write_reg(REG_STEP_LEN, {4'($urandom), len});
      write_reg(REG_COS, {4'($urandom), c});
      write_reg(REG_SIN, {4'($urandom), s});
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      while (recorder.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : result_drain
      int unsigned wait_cycles;
      bit          steady_take;
      segment_type got;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (recorder.beats % 40 == 0) steady_take = ($urandom_range(0, 2) == 0);
         if (recorder.beats == 150 || recorder.beats == 400)
            wait_cycles = HOLD_CYCLES;
         else if (steady_take)
            wait_cycles = 0;
         else
            wait_cycles = $urandom_range(0, MAX_GAP);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got = '{rsp_x_from, rsp_y_from, rsp_x_to, rsp_y_to, rsp_status};
         recorder.check_beat(got);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int unsigned phase, mark, drain_wait;
      recorder      = new();
      counted_items = 0;
      steady_send   = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset settings, every command, stack edges, ignored bytes
      send_symbol(SYM_X, 1'b0);        // from the reset position, no restart
      send_symbol(SYM_X, 1'b1);
      send_symbol(SYM_Y, 1'b0);
      send_symbol(SYM_PLUS, 1'b0);
      send_symbol(SYM_X, 1'b0);
      send_symbol(SYM_MINUS, 1'b0);
      send_symbol(SYM_MINUS, 1'b0);
      send_symbol(SYM_PUSH, 1'b0);
      send_symbol(SYM_Y, 1'b0);
      send_symbol(SYM_PUSH, 1'b0);
      send_symbol(SYM_PLUS, 1'b0);
      send_symbol(SYM_X, 1'b0);
      send_symbol(SYM_POP, 1'b0);
      send_symbol(SYM_X, 1'b0);
      send_symbol(SYM_POP, 1'b0);
      send_symbol(SYM_POP, 1'b0);      // empty stack
      send_symbol(8'h00, 1'b0);
      send_symbol(8'hFF, 1'b0);
      send_symbol(SYM_PUSH, 1'b0);
      send_symbol(8'hFF, 1'b1);        // restart only, also drops the saved frame
      send_symbol(SYM_POP, 1'b0);
      send_symbol(SYM_PUSH, 1'b1);
      send_symbol(SYM_X, 1'b0);
      send_symbol(SYM_POP, 1'b1);      // restart clears the stack first

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase > 0) begin
            req_valid <= 1'b0;
            wait_idle();
            apply_settings(phase);
         end
         mark = counted_items;
         play_sentence(1'b1);
         while (counted_items - mark < PHASE_QUOTA)
            play_sentence($urandom_range(0, 7) == 0);
      end
      req_valid <= 1'b0;

      drain_wait = 0;
      while (recorder.pending.size() != 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (recorder.pending.size() != 0) begin
         $display("%0t: %0d expected result beats never arrived", $time,
                  recorder.pending.size());
         recorder.errors += recorder.pending.size();
      end

      $display("Sent %0d symbols over %0d register settings, random gaps, long holds.",
               counted_items, PHASE_COUNT);
      $display("Checked %0d result beats (%0d overflow, %0d underflow), %0d errors.",
               recorder.beats, recorder.overflows, recorder.underflows, recorder.errors);
      if (recorder.errors == 0)
         $display("turtle_line_segment_generator_top_tb passed");
      else
         $display("turtle_line_segment_generator_top_tb failed");
      $finish;
   end

endmodule

// ===== turtle_line_segment_generator_top.f =====
rtl/core/tlsg_pkg.sv
rtl/core/turtle_line_segment_generator_top.sv
rtl/core/tlsg_checker.sv
tb/turtle_line_segment_generator_top_tb.sv
